/* rtl/ecal_pkg.sv */
package ecal_pkg;

    localparam int MAX_STATES_DEFAULT = 16;
    localparam int CNT_W = 7;
    localparam int SUM_W = 54;
    localparam int VAL_W = 48;
    localparam int MAG_W = 47;
    localparam int GAMMA_W = 18;
    localparam int RGAS_W = 47;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W = 64;
    localparam int PROD_W = 96;

    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
    localparam logic [RGAS_W-1:0] RGAS_RESET = 47'd18811847;
    localparam logic [GAMMA_W-1:0] ONE_Q16 = 18'd65536;
    localparam logic signed [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RGAS = 8'd1;

    typedef enum logic [3:0] {
        STEP_DIV_RHO = 4'd0,
        STEP_DIV_VX  = 4'd1,
        STEP_DIV_VY  = 4'd2,
        STEP_DIV_T   = 4'd3,
        STEP_MUL_VX2 = 4'd4,
        STEP_MUL_VY2 = 4'd5,
        STEP_MUL_RHOT = 4'd6,
        STEP_MUL_P   = 4'd7,
        STEP_MUL_RT  = 4'd8,
        STEP_MUL_GR  = 4'd9,
        STEP_MUL_GRT = 4'd10,
        STEP_SQRT_SPD = 4'd11,
        STEP_SQRT_SND = 4'd12,
        STEP_DIV_Q   = 4'd13
    } step_t;

    typedef struct packed {
        logic  accumulate;
        logic  go;
        logic  finish;
        step_t step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic unit_done;
    } dp_status_t;

    function automatic logic [VAL_W-1:0] magn(input logic signed [VAL_W-1:0] v);
        magn = v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    // signed result from magnitude, saturated to 48 bits
    function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                        input logic [79:0] m);
        logic big;
        big = |m[79:MAG_W];
        if (big)
            sat_mag = neg ? SMIN : SMAX;
        else if (neg)
            sat_mag = -$signed({1'b0, m[MAG_W-1:0]});
        else
            sat_mag = $signed({1'b0, m[MAG_W-1:0]});
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1])
            sat_add = s[VAL_W] ? SMIN : SMAX;
        else
            sat_add = s[VAL_W-1:0];
    endfunction

endpackage

/* rtl/euler_cell_average_linearizer_core.sv */
// channel   direction  handshake                      payload
// state     in         start, busy (taken when !busy) density vel_x vel_y temperature last_state
// result    out        result_valid (one cycle)       avg_* speed pressure sound_speed total_*
// config    in         cfg_valid, cfg_ready           cfg_index, cfg_data
//
// a state that is not last is added to the sums; busy stays low
// a last state starts the cell math: four sum divisions and the energy division
// on a 64-step divider, seven products on a shared multiplier and
// two 48-step square roots, then result_valid
// reset clears the sums, the count and the sequencer; no clearing pass
// the result is shown for one cycle and cannot be stalled
module euler_cell_average_linearizer_core #(
    parameter int MaxStates = ecal_pkg::MAX_STATES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ecal_pkg::VAL_W-1:0]     density,
    input  logic signed [ecal_pkg::VAL_W-1:0]     vel_x,
    input  logic signed [ecal_pkg::VAL_W-1:0]     vel_y,
    input  logic signed [ecal_pkg::VAL_W-1:0]     temperature,
    input  logic                                  last_state,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ecal_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ecal_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  result_valid,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_density,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_vel_x,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_vel_y,
    output logic [ecal_pkg::MAG_W-1:0]            speed,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_temperature,
    output logic signed [ecal_pkg::VAL_W-1:0]     pressure,
    output logic [ecal_pkg::MAG_W-1:0]            sound_speed,
    output logic signed [ecal_pkg::VAL_W-1:0]     total_energy,
    output logic signed [ecal_pkg::VAL_W-1:0]     total_enthalpy
);

    ecal_pkg::ctrl_cmd_t  cmd;
    ecal_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    ecal_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_state (last_state),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    ecal_datapath #(
        .MaxStates (MaxStates)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .density         (density),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .temperature     (temperature),
        .result_valid    (result_valid),
        .avg_density     (avg_density),
        .avg_vel_x       (avg_vel_x),
        .avg_vel_y       (avg_vel_y),
        .speed           (speed),
        .avg_temperature (avg_temperature),
        .pressure        (pressure),
        .sound_speed     (sound_speed),
        .total_energy    (total_energy),
        .total_enthalpy  (total_enthalpy)
    );

endmodule

/* rtl/ecal_div.sv */
module ecal_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ecal_pkg::DIV_W-1:0]     dividend,
    input  logic [ecal_pkg::GAMMA_W-1:0]   divisor,
    output logic                           done,
    output logic [ecal_pkg::DIV_W-1:0]     quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [5:0]                   cnt_reg;
    logic [ecal_pkg::DIV_W-1:0]   quo_reg;
    logic [ecal_pkg::GAMMA_W-1:0] rem_reg;
    logic [ecal_pkg::GAMMA_W-1:0] div_reg;
    logic [ecal_pkg::GAMMA_W:0]   shifted;
    logic [ecal_pkg::GAMMA_W:0]   diff;
    logic                         ge;

    assign shifted = {rem_reg, quo_reg[ecal_pkg::DIV_W-1]};
    assign diff = shifted - {1'b0, div_reg};
    assign ge = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ecal_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[ecal_pkg::GAMMA_W-1:0] : shifted[ecal_pkg::GAMMA_W-1:0];
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/ecal_sqrt.sv */
module ecal_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ecal_pkg::PROD_W-1:0]     radicand,
    output logic                            done,
    output logic [ecal_pkg::VAL_W-1:0]      root
);

    localparam int RootW = ecal_pkg::PROD_W / 2;

    logic                          busy_reg;
    logic                          done_reg;
    logic [5:0]                    cnt_reg;
    logic [ecal_pkg::PROD_W-1:0]   rad_reg;
    logic [RootW:0]                rem_reg;
    logic [RootW-1:0]              root_reg;
    logic [RootW+2:0]              shifted;
    logic [RootW+2:0]              trial;
    logic [RootW+2:0]              diff;
    logic                          ge;

    assign shifted = {rem_reg, rad_reg[ecal_pkg::PROD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff = shifted - trial;
    assign ge = shifted >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(RootW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // digit-by-digit root, two radicand bits a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[ecal_pkg::PROD_W-3:0], 2'b00};
            rem_reg <= ge ? diff[RootW:0] : shifted[RootW:0];
            root_reg <= {root_reg[RootW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/ecal_datapath.sv */
module ecal_datapath #(
    parameter int MaxStates = ecal_pkg::MAX_STATES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ecal_pkg::ctrl_cmd_t                   cmd,
    output ecal_pkg::dp_status_t                  status,
    input  logic                                  cfg_valid,
    input  logic [ecal_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ecal_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [ecal_pkg::VAL_W-1:0]     density,
    input  logic signed [ecal_pkg::VAL_W-1:0]     vel_x,
    input  logic signed [ecal_pkg::VAL_W-1:0]     vel_y,
    input  logic signed [ecal_pkg::VAL_W-1:0]     temperature,
    output logic                                  result_valid,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_density,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_vel_x,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_vel_y,
    output logic [ecal_pkg::MAG_W-1:0]            speed,
    output logic signed [ecal_pkg::VAL_W-1:0]     avg_temperature,
    output logic signed [ecal_pkg::VAL_W-1:0]     pressure,
    output logic [ecal_pkg::MAG_W-1:0]            sound_speed,
    output logic signed [ecal_pkg::VAL_W-1:0]     total_energy,
    output logic signed [ecal_pkg::VAL_W-1:0]     total_enthalpy
);

    localparam int VW = ecal_pkg::VAL_W;
    localparam int SW = ecal_pkg::SUM_W;

    logic [ecal_pkg::GAMMA_W-1:0] gamma_reg;
    logic [ecal_pkg::RGAS_W-1:0]  rgas_reg;

    logic signed [SW-1:0] sum_rho_reg, sum_vx_reg, sum_vy_reg, sum_t_reg;
    logic [ecal_pkg::CNT_W-1:0] count_reg;

    logic signed [VW-1:0] rho_reg, vx_reg, vy_reg, t_reg;
    logic signed [VW-1:0] rhot_reg, p_reg, rt_reg, gr_reg, grt_reg, q_reg;
    logic [ecal_pkg::PROD_W-1:0] v2_reg;
    logic [ecal_pkg::MAG_W-1:0] spd_reg, snd_reg;

    // shared multiplier, 48 x 16 a cycle, partial products accumulated
    logic                        mul_busy_reg;
    logic                        mul_done_reg;
    logic [1:0]                  mul_cnt_reg;
    logic [VW-1:0]               mul_a_reg, mul_b_reg;
    logic [ecal_pkg::PROD_W-1:0] mul_acc_reg;
    logic [VW+15:0]              partial;
    logic [ecal_pkg::PROD_W-1:0] partial_sh;

    logic                        is_div, is_sqrt, is_mul;
    logic [ecal_pkg::DIV_W-1:0]  div_dividend;
    logic [ecal_pkg::GAMMA_W-1:0] div_divisor;
    logic                        div_done;
    logic [ecal_pkg::DIV_W-1:0]  div_quo;
    logic [ecal_pkg::PROD_W-1:0] sqrt_rad;
    logic                        sqrt_done;
    logic [VW-1:0]               sqrt_root;
    logic [VW-1:0]               op_a, op_b;
    logic                        op_neg;
    logic signed [SW-1:0]        sum_sel;
    logic [SW-1:0]               sum_mag;
    logic [ecal_pkg::GAMMA_W-1:0] gm1;
    logic signed [VW-1:0]        mq;
    logic signed [VW-1:0]        avg_q;
    logic signed [VW-1:0]        half;
    logic signed [VW-1:0]        energy;
    logic                        room;

    always_comb
    begin
        is_div = 1'b0;
        is_sqrt = 1'b0;
        is_mul = 1'b0;
        case (cmd.step)
            ecal_pkg::STEP_DIV_RHO, ecal_pkg::STEP_DIV_VX, ecal_pkg::STEP_DIV_VY,
            ecal_pkg::STEP_DIV_T, ecal_pkg::STEP_DIV_Q: is_div = 1'b1;
            ecal_pkg::STEP_SQRT_SPD, ecal_pkg::STEP_SQRT_SND: is_sqrt = 1'b1;
            default: is_mul = 1'b1;
        endcase
    end

    assign gm1 = (gamma_reg > ecal_pkg::ONE_Q16) ? (gamma_reg - ecal_pkg::ONE_Q16)
                                                 : ecal_pkg::GAMMA_W'(1);

    always_comb
    begin
        case (cmd.step)
            ecal_pkg::STEP_DIV_VX: sum_sel = sum_vx_reg;
            ecal_pkg::STEP_DIV_VY: sum_sel = sum_vy_reg;
            ecal_pkg::STEP_DIV_T:  sum_sel = sum_t_reg;
            default:               sum_sel = sum_rho_reg;
        endcase
    end

    assign sum_mag = sum_sel[SW-1] ? (~sum_sel + 1'b1) : sum_sel;

    always_comb
    begin
        if (cmd.step == ecal_pkg::STEP_DIV_Q)
        begin
            div_dividend = {ecal_pkg::magn(rt_reg), 16'd0};
            div_divisor = gm1;
        end
        else
        begin
            div_dividend = {{(ecal_pkg::DIV_W-SW){1'b0}}, sum_mag};
            div_divisor = {{(ecal_pkg::GAMMA_W-ecal_pkg::CNT_W){1'b0}}, count_reg};
        end
    end

    always_comb
    begin
        if (cmd.step == ecal_pkg::STEP_SQRT_SPD)
            sqrt_rad = v2_reg;
        else if (!grt_reg[VW-1] && (grt_reg != '0))
            sqrt_rad = {33'd0, grt_reg[VW-2:0], 16'd0};
        else
            sqrt_rad = '0;
    end

    always_comb
    begin
        op_a = ecal_pkg::magn(vx_reg);
        op_b = ecal_pkg::magn(vx_reg);
        op_neg = 1'b0;
        case (cmd.step)
            ecal_pkg::STEP_MUL_VY2:
            begin
                op_a = ecal_pkg::magn(vy_reg);
                op_b = ecal_pkg::magn(vy_reg);
            end
            ecal_pkg::STEP_MUL_RHOT:
            begin
                op_a = ecal_pkg::magn(rho_reg);
                op_b = ecal_pkg::magn(t_reg);
                op_neg = rho_reg[VW-1] ^ t_reg[VW-1];
            end
            ecal_pkg::STEP_MUL_P:
            begin
                op_a = ecal_pkg::magn(rhot_reg);
                op_b = {1'b0, rgas_reg};
                op_neg = rhot_reg[VW-1];
            end
            ecal_pkg::STEP_MUL_RT:
            begin
                op_a = {1'b0, rgas_reg};
                op_b = ecal_pkg::magn(t_reg);
                op_neg = t_reg[VW-1];
            end
            ecal_pkg::STEP_MUL_GR:
            begin
                op_a = {{(VW-ecal_pkg::GAMMA_W){1'b0}}, gamma_reg};
                op_b = {1'b0, rgas_reg};
            end
            ecal_pkg::STEP_MUL_GRT:
            begin
                op_a = ecal_pkg::magn(gr_reg);
                op_b = ecal_pkg::magn(t_reg);
                op_neg = gr_reg[VW-1] ^ t_reg[VW-1];
            end
            default:
            begin
                op_neg = 1'b0;
            end
        endcase
    end

    ecal_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.go && is_div),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    ecal_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.go && is_sqrt),
        .radicand (sqrt_rad),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        case (mul_cnt_reg)
            2'd0: partial = mul_a_reg * mul_b_reg[15:0];
            2'd1: partial = mul_a_reg * mul_b_reg[31:16];
            default: partial = mul_a_reg * mul_b_reg[47:32];
        endcase
    end

    always_comb
    begin
        case (mul_cnt_reg)
            2'd0: partial_sh = {32'd0, partial};
            2'd1: partial_sh = {16'd0, partial, 16'd0};
            default: partial_sh = {partial, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.go && is_mul)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd2)
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go && is_mul)
        begin
            mul_a_reg <= op_a;
            mul_b_reg <= op_b;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            mul_acc_reg <= mul_acc_reg + partial_sh;
        end
    end

    assign status.unit_done = div_done | sqrt_done | mul_done_reg;

    assign mq = ecal_pkg::sat_mag(op_neg, mul_acc_reg[ecal_pkg::PROD_W-1:16]);
    assign avg_q = sum_sel[SW-1] ? -$signed(div_quo[VW-1:0]) : $signed(div_quo[VW-1:0]);
    assign half = ecal_pkg::sat_mag(1'b0, {1'b0, v2_reg[ecal_pkg::PROD_W-1:17]});
    assign energy = ecal_pkg::sat_add(q_reg, half);
    assign room = count_reg < ecal_pkg::CNT_W'(MaxStates);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= ecal_pkg::GAMMA_RESET;
            rgas_reg <= ecal_pkg::RGAS_RESET;
            sum_rho_reg <= '0;
            sum_vx_reg <= '0;
            sum_vy_reg <= '0;
            sum_t_reg <= '0;
            count_reg <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == ecal_pkg::REG_GAMMA)
                gamma_reg <= cfg_data[ecal_pkg::GAMMA_W-1:0];
            if (cfg_valid && cfg_index == ecal_pkg::REG_RGAS)
                rgas_reg <= cfg_data[ecal_pkg::RGAS_W-1:0];
            result_valid <= cmd.finish;
            if (cmd.finish)
            begin
                sum_rho_reg <= '0;
                sum_vx_reg <= '0;
                sum_vy_reg <= '0;
                sum_t_reg <= '0;
                count_reg <= '0;
            end
            else if (cmd.accumulate && room)
            begin
                // states past the limit are dropped
                sum_rho_reg <= sum_rho_reg + SW'(density);
                sum_vx_reg <= sum_vx_reg + SW'(vel_x);
                sum_vy_reg <= sum_vy_reg + SW'(vel_y);
                sum_t_reg <= sum_t_reg + SW'(temperature);
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.unit_done)
        begin
            case (cmd.step)
                ecal_pkg::STEP_DIV_RHO: rho_reg <= avg_q;
                ecal_pkg::STEP_DIV_VX:  vx_reg <= avg_q;
                ecal_pkg::STEP_DIV_VY:  vy_reg <= avg_q;
                ecal_pkg::STEP_DIV_T:   t_reg <= avg_q;
                ecal_pkg::STEP_MUL_VX2: v2_reg <= mul_acc_reg;
                ecal_pkg::STEP_MUL_VY2: v2_reg <= v2_reg + mul_acc_reg;
                ecal_pkg::STEP_MUL_RHOT: rhot_reg <= mq;
                ecal_pkg::STEP_MUL_P:   p_reg <= mq;
                ecal_pkg::STEP_MUL_RT:  rt_reg <= mq;
                ecal_pkg::STEP_MUL_GR:  gr_reg <= mq;
                ecal_pkg::STEP_MUL_GRT: grt_reg <= mq;
                ecal_pkg::STEP_SQRT_SPD:
                    spd_reg <= sqrt_root[VW-1] ? {ecal_pkg::MAG_W{1'b1}}
                                               : sqrt_root[ecal_pkg::MAG_W-1:0];
                ecal_pkg::STEP_SQRT_SND: snd_reg <= sqrt_root[ecal_pkg::MAG_W-1:0];
                ecal_pkg::STEP_DIV_Q:
                    q_reg <= ecal_pkg::sat_mag(rt_reg[VW-1], {16'd0, div_quo});
                default: q_reg <= q_reg;
            endcase
        end
        if (cmd.finish)
        begin
            avg_density <= rho_reg;
            avg_vel_x <= vx_reg;
            avg_vel_y <= vy_reg;
            speed <= spd_reg;
            avg_temperature <= t_reg;
            pressure <= p_reg;
            sound_speed <= snd_reg;
            total_energy <= energy;
            total_enthalpy <= ecal_pkg::sat_add(energy, rt_reg);
        end
    end

endmodule

/* rtl/ecal_ctrl.sv */
module ecal_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last_state,
    input  ecal_pkg::dp_status_t  status,
    output ecal_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    ecal_pkg::step_t step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last_state)
                begin
                    state_next = ST_ISSUE;
                    step_next = ecal_pkg::STEP_DIV_RHO;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (status.unit_done)
                begin
                    if (step_reg == ecal_pkg::STEP_DIV_Q)
                        state_next = ST_FINISH;
                    else
                    begin
                        state_next = ST_ISSUE;
                        step_next = ecal_pkg::step_t'(step_reg + 4'd1);
                    end
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= ecal_pkg::STEP_DIV_RHO;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign cmd.accumulate = start && (state_reg == ST_IDLE);
    assign cmd.go = (state_reg == ST_ISSUE);
    assign cmd.finish = (state_reg == ST_FINISH);
    assign cmd.step = step_reg;

endmodule
